FILE: hdl/keyboard_byte_to_hid_report_unit_defines.svh
// Assertion macros shared by the keyboard report translator RTL.
// Self-contained; the clocking assumes signals named clk and rst in the including module.
`ifndef KEYBOARD_BYTE_TO_HID_REPORT_UNIT_DEFINES_SVH
`define KEYBOARD_BYTE_TO_HID_REPORT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define KBH_ASSERT_HOLDS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("kbh assertion failed");
`define KBH_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kbh assertion failed");
`else
`define KBH_ASSERT_HOLDS(lbl, cond)
`define KBH_ASSERT_IMPLIES(lbl, ante, cons)
`endif

`endif

FILE: hdl/kbh_pkg.sv
// Shared types, codes and the key translation ROM for the keyboard report translator.
// No dependencies.
package kbh_pkg;

  localparam int KBH_QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_JOY    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [7:0] BYTE_ANNOUNCE_0 = 8'h80;
  localparam logic [7:0] BYTE_ANNOUNCE_1 = 8'h81;
  localparam logic [7:0] BYTE_JOY_LO     = 8'ha0;
  localparam logic [7:0] BYTE_JOY_HI     = 8'hbf;

  // ROM word: usage in bits 7..0, then control, shift, status, down-only, up-only.
  localparam logic [13:0] ROM_CT = 14'h0100;
  localparam logic [13:0] ROM_SH = 14'h0200;
  localparam logic [13:0] ROM_ER = 14'h0400;
  localparam logic [13:0] ROM_DN = 14'h1000;
  localparam logic [13:0] ROM_UP = 14'h2000;

  // One classified byte: the first result's fields plus a flag for a trailing release.
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] modifiers;
    logic [7:0] keycode;
    logic       stick;
    logic [3:0] directions;
    logic       fire;
    logic [2:0] status_code;
    logic       two;
  } kbh_cmd_t;

  function automatic logic [13:0] key_rom(input logic [7:0] c);
    logic [13:0] v;
    v = '0;
    if ((c >= 8'h01 && c <= 8'h07) || c == 8'h0b || c == 8'h0c ||
        (c >= 8'h0e && c <= 8'h1a)) begin
      v = ROM_CT | {6'd0, c + 8'h03};
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      v = ROM_SH | {6'd0, c - 8'h3d};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      v = {6'd0, c - 8'h5d};
    end else if (c >= 8'h31 && c <= 8'h39) begin
      v = {6'd0, c - 8'h13};
    end else if (c >= 8'h90 && c <= 8'h95) begin
      v = ROM_ER | {11'd0, c[2:0]};
    end else begin
      case (c)
        8'h00: v = ROM_CT | ROM_SH | 14'h1f;
        8'h08: v = 14'h2a;
        8'h09: v = 14'h2b;
        8'h0a: v = 14'h28;
        8'h0d: v = 14'h28;
        8'h1b: v = 14'h29;
        8'h1c: v = ROM_CT | ROM_SH | 14'h36;
        8'h1d: v = ROM_CT | 14'h30;
        8'h1e: v = ROM_CT | ROM_SH | 14'h23;
        8'h1f: v = ROM_CT | ROM_SH | 14'h2d;
        8'h20: v = 14'h2c;
        8'h21: v = ROM_SH | 14'h1e;
        8'h22: v = ROM_SH | 14'h34;
        8'h23: v = ROM_SH | 14'h20;
        8'h24: v = ROM_SH | 14'h21;
        8'h25: v = ROM_SH | 14'h22;
        8'h26: v = ROM_SH | 14'h24;
        8'h27: v = 14'h34;
        8'h28: v = ROM_SH | 14'h26;
        8'h29: v = ROM_SH | 14'h27;
        8'h2a: v = ROM_SH | 14'h25;
        8'h2b: v = ROM_SH | 14'h2e;
        8'h2c: v = 14'h36;
        8'h2d: v = 14'h2d;
        8'h2e: v = 14'h37;
        8'h2f: v = 14'h38;
        8'h30: v = 14'h27;
        8'h3a: v = ROM_SH | 14'h33;
        8'h3b: v = 14'h33;
        8'h3c: v = ROM_SH | 14'h36;
        8'h3d: v = 14'h2e;
        8'h3e: v = ROM_SH | 14'h37;
        8'h3f: v = ROM_SH | 14'h38;
        8'h40: v = ROM_SH | 14'h1f;
        8'h5b: v = 14'h2f;
        8'h5d: v = 14'h30;
        8'h5e: v = ROM_SH | 14'h23;
        8'h5f: v = ROM_SH | 14'h2d;
        8'h7b: v = ROM_SH | 14'h2f;
        8'h7d: v = ROM_SH | 14'h30;
        8'h7f: v = 14'h2a;
        8'he0: v = ROM_DN | 14'h4f;
        8'he1: v = ROM_DN | 14'h50;
        8'he2: v = ROM_DN | 14'h51;
        8'he3: v = ROM_DN | 14'h52;
        8'he4: v = ROM_DN | 14'h4e;
        8'he5: v = ROM_DN | 14'h4b;
        8'he9: v = ROM_DN | 14'h48;
        8'hf0: v = ROM_UP | 14'h4f;
        8'hf1: v = ROM_UP | 14'h50;
        8'hf2: v = ROM_UP | 14'h51;
        8'hf3: v = ROM_UP | 14'h52;
        8'hf4: v = ROM_UP | 14'h4e;
        8'hf5: v = ROM_UP | 14'h4b;
        8'hf9: v = ROM_UP | 14'h48;
        default: v = '0;
      endcase
    end
    return v;
  endfunction

endpackage

FILE: hdl/keyboard_byte_to_hid_report_unit.sv
// Keyboard byte to HID report translator, top level.
// With nothing ahead of it, a byte's first result is written into the command queue and
// then loaded into the output register that drives the result ports.
// Throughput: one byte per cycle for bytes with at most one result, while results are
// popped and the queue has room; a plain key holds the register for press and release.
// Reset (synchronous, rst high) clears the joystick announcement, the command
// queue and the output register's valid and release-pending flags.
module keyboard_byte_to_hid_report_unit #(
  parameter int QUEUE_DEPTH = kbh_pkg::KBH_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [1:0] modifiers,
  output logic [7:0] keycode,
  output logic       stick,
  output logic [3:0] directions,
  output logic       fire,
  output logic [2:0] status_code,
  output logic       last
);

  kbh_pkg::kbh_cmd_t wr_cmd;
  kbh_pkg::kbh_cmd_t rd_cmd;
  logic              cmd_wr;
  logic              cmd_pop;
  logic              q_full;
  logic              q_empty;

  kbh_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .rx_byte (rx_byte),
    .q_full  (q_full),
    .full    (full),
    .cmd_wr  (cmd_wr),
    .cmd     (wr_cmd)
  );

  kbh_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_wr),
    .wr_data (wr_cmd),
    .full    (q_full),
    .rd      (cmd_pop),
    .rd_data (rd_cmd),
    .empty   (q_empty)
  );

  kbh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_data      (rd_cmd),
    .cmd_pop     (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .kind        (kind),
    .modifiers   (modifiers),
    .keycode     (keycode),
    .stick       (stick),
    .directions  (directions),
    .fire        (fire),
    .status_code (status_code),
    .last        (last)
  );

endmodule

FILE: hdl/kbh_front.sv
// Front end: accepts keyboard bytes, tracks the joystick announcement and
// classifies each byte into a command. Depends on kbh_pkg.
module kbh_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [7:0]         rx_byte,
  input  logic               q_full,
  output logic               full,
  output logic               cmd_wr,
  output kbh_pkg::kbh_cmd_t  cmd
);

  // Bit 1 set: an announcement is pending; bit 0 names the joystick.
  logic [1:0]  pending_stick;
  logic [1:0]  pending_stick_next;
  logic        cmd_valid;
  logic [13:0] rom;
  logic        accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign cmd_wr = push && cmd_valid;
  assign rom    = kbh_pkg::key_rom(rx_byte);

  always_comb begin
    cmd                = '0;
    cmd_valid          = 1'b0;
    pending_stick_next = 2'b00;
    if (rx_byte == kbh_pkg::BYTE_ANNOUNCE_0 || rx_byte == kbh_pkg::BYTE_ANNOUNCE_1) begin
      pending_stick_next = {1'b1, rx_byte[0]};
    end else if (rx_byte >= kbh_pkg::BYTE_JOY_LO && rx_byte <= kbh_pkg::BYTE_JOY_HI) begin
      // Joystick data without an announcement is dropped.
      cmd_valid       = pending_stick[1];
      cmd.kind        = kbh_pkg::KIND_JOY;
      cmd.stick       = pending_stick[0];
      cmd.directions  = rx_byte[3:0];
      cmd.fire        = rx_byte[4];
    end else if (rom != '0) begin
      cmd_valid = 1'b1;
      if ((rom & kbh_pkg::ROM_ER) != '0) begin
        cmd.kind        = kbh_pkg::KIND_STATUS;
        cmd.status_code = rom[2:0];
      end else if ((rom & kbh_pkg::ROM_UP) != '0) begin
        cmd.kind = kbh_pkg::KIND_KEY;
      end else begin
        cmd.kind      = kbh_pkg::KIND_KEY;
        cmd.modifiers = rom[9:8];
        cmd.keycode   = rom[7:0];
        cmd.two       = (rom & kbh_pkg::ROM_DN) == '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_stick <= 2'b00;
    end else if (accept) begin
      pending_stick <= pending_stick_next;
    end
  end

endmodule

FILE: hdl/kbh_cmd_queue.sv
// Short first-word-fall-through command queue between front and back ends.
// Depends on kbh_pkg.
module kbh_cmd_queue #(
  parameter int DEPTH = kbh_pkg::KBH_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr,
  input  kbh_pkg::kbh_cmd_t  wr_data,
  output logic               full,
  input  logic               rd,
  output kbh_pkg::kbh_cmd_t  rd_data,
  output logic               empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  kbh_pkg::kbh_cmd_t entries [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wrap_inc(wptr);
      end
      if (do_rd) begin
        rptr <= wrap_inc(rptr);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_data;
    end
  end

endmodule

FILE: hdl/kbh_back.sv
// Back end: expands queued commands into result items in an output register,
// adding the release report after a plain key press. Depends on kbh_pkg and the defines header.
`include "keyboard_byte_to_hid_report_unit_defines.svh"

module kbh_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  kbh_pkg::kbh_cmd_t  q_data,
  output logic               cmd_pop,
  input  logic               pop,
  output logic               empty,
  output logic [1:0]         kind,
  output logic [1:0]         modifiers,
  output logic [7:0]         keycode,
  output logic               stick,
  output logic [3:0]         directions,
  output logic               fire,
  output logic [2:0]         status_code,
  output logic               last
);

  logic       out_valid;
  logic       rel_pending;
  logic       out_free;
  logic [1:0] out_kind;
  logic       out_last;

  // The output register can take a new result when it is empty or being drained.
  assign out_free = !out_valid || pop;
  assign cmd_pop  = out_free && !rel_pending && !q_empty;
  assign empty    = !out_valid;
  assign kind     = out_kind;
  assign last     = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      rel_pending <= 1'b0;
    end else if (out_free) begin
      if (rel_pending) begin
        out_valid   <= 1'b1;
        rel_pending <= 1'b0;
      end else begin
        out_valid   <= !q_empty;
        rel_pending <= !q_empty && q_data.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (rel_pending) begin
        out_kind    <= kbh_pkg::KIND_KEY;
        modifiers   <= '0;
        keycode     <= '0;
        stick       <= 1'b0;
        directions  <= '0;
        fire        <= 1'b0;
        status_code <= '0;
        out_last    <= 1'b1;
      end else begin
        out_kind    <= q_data.kind;
        modifiers   <= q_data.modifiers;
        keycode     <= q_data.keycode;
        stick       <= q_data.stick;
        directions  <= q_data.directions;
        fire        <= q_data.fire;
        status_code <= q_data.status_code;
        out_last    <= !q_data.two;
      end
    end
  end

  `KBH_ASSERT_IMPLIES(a_release_follows_press, rel_pending, out_valid && !out_last && out_kind == kbh_pkg::KIND_KEY)
  `KBH_ASSERT_IMPLIES(a_no_pop_mid_pair, cmd_pop, !rel_pending)
  `KBH_ASSERT_HOLDS(a_single_result_last, !out_valid || out_kind == kbh_pkg::KIND_KEY || out_last)

endmodule

FILE: verif/tb.sv
// Self-checking testbench for keyboard_byte_to_hid_report_unit: a scoreboard class predicts
// the reports for every byte transfer and checks each report as it is popped.
// Depends on kbh_pkg for the kind codes, the special byte values and the ROM flag bits.
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0]  KIND_KEY        = kbh_pkg::KIND_KEY;
  localparam logic [1:0]  KIND_JOY        = kbh_pkg::KIND_JOY;
  localparam logic [1:0]  KIND_STATUS     = kbh_pkg::KIND_STATUS;
  localparam logic [7:0]  BYTE_ANNOUNCE_0 = kbh_pkg::BYTE_ANNOUNCE_0;
  localparam logic [7:0]  BYTE_ANNOUNCE_1 = kbh_pkg::BYTE_ANNOUNCE_1;
  localparam logic [7:0]  BYTE_JOY_LO     = kbh_pkg::BYTE_JOY_LO;
  localparam logic [7:0]  BYTE_JOY_HI     = kbh_pkg::BYTE_JOY_HI;
  localparam logic [13:0] ROM_CT          = kbh_pkg::ROM_CT;
  localparam logic [13:0] ROM_SH          = kbh_pkg::ROM_SH;
  localparam logic [13:0] ROM_ER          = kbh_pkg::ROM_ER;
  localparam logic [13:0] ROM_DN          = kbh_pkg::ROM_DN;
  localparam logic [13:0] ROM_UP          = kbh_pkg::ROM_UP;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] modifiers;
    logic [7:0] keycode;
    logic       stick;
    logic [3:0] directions;
    logic       fire;
    logic [2:0] status_code;
    logic       last;
  } hid_report_t;

  class hid_report_tracker;
    hid_report_t awaited_reports[$];
    logic [1:0]  stick_mark;
    int          mismatches;
    int          noted_bytes;

    function new();
      stick_mark  = 2'b00;
      mismatches  = 0;
      noted_bytes = 0;
    endfunction

    // Translation table word: usage in bits 7..0 plus the control, shift, status,
    // down-only and up-only flags.
    function logic [13:0] table_word(input logic [7:0] c);
      logic [13:0] w;
      logic [13:0] usage;
      usage = {9'd0, c[4:0]} + 14'd3;
      w = '0;
      case (c)
        8'h00: w = ROM_CT | ROM_SH | 14'h1f;
        8'h08: w = 14'h2a;
        8'h09: w = 14'h2b;
        8'h0a, 8'h0d: w = 14'h28;
        8'h1b: w = 14'h29;
        8'h1c: w = ROM_CT | ROM_SH | 14'h36;
        8'h1d: w = ROM_CT | 14'h30;
        8'h1e: w = ROM_CT | ROM_SH | 14'h23;
        8'h1f: w = ROM_CT | ROM_SH | 14'h2d;
        8'h20: w = 14'h2c;
        8'h21: w = ROM_SH | 14'h1e;
        8'h22: w = ROM_SH | 14'h34;
        8'h23: w = ROM_SH | 14'h20;
        8'h24: w = ROM_SH | 14'h21;
        8'h25: w = ROM_SH | 14'h22;
        8'h26: w = ROM_SH | 14'h24;
        8'h27: w = 14'h34;
        8'h28: w = ROM_SH | 14'h26;
        8'h29: w = ROM_SH | 14'h27;
        8'h2a: w = ROM_SH | 14'h25;
        8'h2b: w = ROM_SH | 14'h2e;
        8'h2c: w = 14'h36;
        8'h2d: w = 14'h2d;
        8'h2e: w = 14'h37;
        8'h2f: w = 14'h38;
        8'h30: w = 14'h27;
        8'h31: w = 14'h1e;
        8'h32: w = 14'h1f;
        8'h33: w = 14'h20;
        8'h34: w = 14'h21;
        8'h35: w = 14'h22;
        8'h36: w = 14'h23;
        8'h37: w = 14'h24;
        8'h38: w = 14'h25;
        8'h39: w = 14'h26;
        8'h3a: w = ROM_SH | 14'h33;
        8'h3b: w = 14'h33;
        8'h3c: w = ROM_SH | 14'h36;
        8'h3d: w = 14'h2e;
        8'h3e: w = ROM_SH | 14'h37;
        8'h3f: w = ROM_SH | 14'h38;
        8'h40: w = ROM_SH | 14'h1f;
        8'h5b: w = 14'h2f;
        8'h5d: w = 14'h30;
        8'h5e: w = ROM_SH | 14'h23;
        8'h5f: w = ROM_SH | 14'h2d;
        8'h7b: w = ROM_SH | 14'h2f;
        8'h7d: w = ROM_SH | 14'h30;
        8'h7f: w = 14'h2a;
        8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95: w = ROM_ER | {11'd0, c[2:0]};
        8'he0: w = ROM_DN | 14'h4f;
        8'he1: w = ROM_DN | 14'h50;
        8'he2: w = ROM_DN | 14'h51;
        8'he3: w = ROM_DN | 14'h52;
        8'he4: w = ROM_DN | 14'h4e;
        8'he5: w = ROM_DN | 14'h4b;
        8'he9: w = ROM_DN | 14'h48;
        8'hf0: w = ROM_UP | 14'h4f;
        8'hf1: w = ROM_UP | 14'h50;
        8'hf2: w = ROM_UP | 14'h51;
        8'hf3: w = ROM_UP | 14'h52;
        8'hf4: w = ROM_UP | 14'h4e;
        8'hf5: w = ROM_UP | 14'h4b;
        8'hf9: w = ROM_UP | 14'h48;
        default: begin
          // Letters and control letters: the low five bits 1..26 map to usages 0x04..0x1d.
          if (c[4:0] >= 5'd1 && c[4:0] <= 5'd26) begin
            case (c[7:5])
              3'd0: w = ROM_CT | usage;
              3'd2: w = ROM_SH | usage;
              3'd3: w = usage;
              default: w = '0;
            endcase
          end
        end
      endcase
      return w;
    endfunction

    function void note_byte(input logic [7:0] c);
      hid_report_t r;
      logic [13:0] w;
      r = '0;
      noted_bytes++;
      if (c == BYTE_ANNOUNCE_0 || c == BYTE_ANNOUNCE_1) begin
        stick_mark = {1'b1, c[0]};
      end else if (c >= BYTE_JOY_LO && c <= BYTE_JOY_HI) begin
        // Joystick data only counts after an announcement; otherwise it is dropped.
        if (stick_mark[1]) begin
          r.kind       = KIND_JOY;
          r.stick      = stick_mark[0];
          r.directions = c[3:0];
          r.fire       = c[4];
          r.last       = 1'b1;
          awaited_reports.push_back(r);
          stick_mark = 2'b00;
        end
      end else begin
        stick_mark = 2'b00;
        w = table_word(c);
        if (w != '0) begin
          r.last = 1'b1;
          if ((w & ROM_ER) != '0) begin
            r.kind        = KIND_STATUS;
            r.status_code = w[2:0];
            awaited_reports.push_back(r);
          end else if ((w & ROM_UP) != '0) begin
            r.kind = KIND_KEY;
            awaited_reports.push_back(r);
          end else begin
            r.kind      = KIND_KEY;
            r.modifiers = w[9:8];
            r.keycode   = w[7:0];
            if ((w & ROM_DN) != '0) begin
              awaited_reports.push_back(r);
            end else begin
              // A plain key is a press report followed by a release report.
              r.last = 1'b0;
              awaited_reports.push_back(r);
              r = '0;
              r.kind = KIND_KEY;
              r.last = 1'b1;
              awaited_reports.push_back(r);
            end
          end
        end
      end
    endfunction

    function string describe(input hid_report_t r);
      return $sformatf("kind=%0d mods=%0d key=%02h stick=%0d dir=%h fire=%0d status=%0d last=%0d",
                       r.kind, r.modifiers, r.keycode, r.stick, r.directions, r.fire,
                       r.status_code, r.last);
    endfunction

    function void check_report(input hid_report_t got);
      hid_report_t want;
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report: %s", describe(got));
      end else begin
        want = awaited_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("report mismatch at %0t", $realtime);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
          end
        end
      end
    endfunction

    function int outstanding();
      return awaited_reports.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       full;
  logic       empty;
  logic [1:0] kind;
  logic [1:0] modifiers;
  logic [7:0] keycode;
  logic       stick;
  logic [3:0] directions;
  logic       fire;
  logic [2:0] status_code;
  logic       last;

  int send_idle_pct = 20;
  int recv_idle_pct = 56;

  hid_report_tracker tracker = new();

  keyboard_byte_to_hid_report_unit uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .modifiers(modifiers),
    .keycode(keycode),
    .stick(stick),
    .directions(directions),
    .fire(fire),
    .status_code(status_code),
    .last(last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: check at each edge with the values from before it, then choose pop.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        tracker.check_report({kind, modifiers, keycode, stick, directions, fire,
                              status_code, last});
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.note_byte(b);
  endtask

  task automatic drain_reports();
    push <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] directed_bytes[$];
    int pick;
    int target;
    directed_bytes = '{8'h00, 8'hff, 8'h80, 8'ha0, 8'h81, 8'hbf, 8'ha5,
                       8'h80, 8'h81, 8'hb3, 8'h80, 8'h41, 8'ha0,
                       8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95,
                       8'he0, 8'hf0, 8'h61, 8'h5c, 8'h01, 8'h1c};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    target = tracker.noted_bytes;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 20; recv_idle_pct = 56; end
        1: begin send_idle_pct = 56; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      target += 275;
      while (tracker.noted_bytes < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          send_byte({7'h40, 1'($urandom_range(0, 1))});
          send_byte({3'b101, 5'($urandom_range(0, 31))});
        end else if (pick < 45) begin
          // A second announcement replaces the first.
          send_byte({7'h40, 1'($urandom_range(0, 1))});
          send_byte({7'h40, 1'($urandom_range(0, 1))});
          send_byte({3'b101, 5'($urandom_range(0, 31))});
        end else if (pick < 55) begin
          send_byte({7'h40, 1'($urandom_range(0, 1))});
          send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_byte(8'($urandom_range(0, 255)));
        end
      end
      // Hold the sender off until every outstanding report has been popped.
      drain_reports();
    end

    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/kbh_pkg.sv
hdl/kbh_front.sv
hdl/kbh_cmd_queue.sv
hdl/kbh_back.sv
hdl/keyboard_byte_to_hid_report_unit.sv
verif/tb.sv
